/* design/gtg_pkg.sv */
// Package: shared types, constants and arctangent table for the go-to-goal controller.
package gtg_pkg;
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W = $clog2(CORDIC_STEPS + 1);
	localparam int CW = 36;
	localparam int ZW = 32;
	localparam logic signed [ZW-1:0] HALF_PI_Q29 = 32'sd843314857;
	localparam logic signed [17:0] PI_Q13 = 18'sd25736;
	localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

	typedef enum logic [1:0] {
		MODE_STOP = 2'd0,
		MODE_MOVE = 2'd1,
		MODE_ROT  = 2'd2,
		MODE_RSV  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		CFG_TOL   = 3'd0,
		CFG_MAXL  = 3'd1,
		CFG_MINL  = 3'd2,
		CFG_HGAIN = 3'd3,
		CFG_AGAIN = 3'd4,
		CFG_SPIN  = 3'd5,
		CFG_THR   = 3'd6,
		CFG_NONE  = 3'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_GOAL, ST_PRE, ST_ITER, ST_MUL1, ST_MUL2, ST_SUM, ST_LIN,
		ST_ERR, ST_FIN, ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic goal;
		logic pre;
		logic iter;
		logic mul1;
		logic mul2;
		logic sum;
		logic lin;
		logic err;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic is_goal;
		logic active;
		logic iter_done;
	} sts_t;

	function automatic logic [ZW-1:0] atan_q29(input logic [4:0] i);
		logic [ZW-1:0] r;
		begin
			unique case (i)
				5'd0: r = 32'd421657428;
				5'd1: r = 32'd248918915;
				5'd2: r = 32'd131521918;
				5'd3: r = 32'd66762579;
				5'd4: r = 32'd33510843;
				5'd5: r = 32'd16771758;
				5'd6: r = 32'd8387925;
				5'd7: r = 32'd4194219;
				5'd8: r = 32'd2097141;
				5'd9: r = 32'd1048575;
				5'd30, 5'd31: r = 32'd0;
				default: r = 32'd1 << (5'd29 - i);
			endcase
			atan_q29 = r;
		end
	endfunction
endpackage

/* design/gtg_ctrl.sv */
// Controller: sequences one item through the datapath.
module gtg_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  gtg_pkg::sts_t   sts,
	output gtg_pkg::cmd_t   cmd
);
	import gtg_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_nx = ST_GOAL;
			ST_GOAL: begin
				if (sts.is_goal) state_nx = ST_IDLE;
				else if (!sts.active) state_nx = ST_FIN;
				else state_nx = ST_PRE;
			end
			ST_PRE:  state_nx = ST_ITER;
			ST_ITER: if (sts.iter_done) state_nx = ST_MUL1;
			ST_MUL1: state_nx = ST_MUL2;
			ST_MUL2: state_nx = ST_SUM;
			ST_SUM:  state_nx = ST_LIN;
			ST_LIN:  state_nx = ST_ERR;
			ST_ERR:  state_nx = ST_FIN;
			ST_FIN:  state_nx = ST_OUT;
			ST_OUT:  if (!out_stall) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT);
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.goal = (state_q == ST_GOAL);
		cmd.pre = (state_q == ST_PRE);
		cmd.iter = (state_q == ST_ITER);
		cmd.mul1 = (state_q == ST_MUL1);
		cmd.mul2 = (state_q == ST_MUL2);
		cmd.sum = (state_q == ST_SUM);
		cmd.lin = (state_q == ST_LIN);
		cmd.err = (state_q == ST_ERR);
		cmd.fin = (state_q == ST_FIN);
	end
endmodule

/* design/gtg_dp.sv */
// Datapath: goal state, CORDIC vectoring unit, scaling and command arithmetic.
module gtg_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  gtg_pkg::cmd_t       cmd,
	output gtg_pkg::sts_t       sts,
	input  logic                operation,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [15:0]  yaw,
	input  logic [30:0]         reach_radius,
	input  logic [30:0]         max_linear,
	input  logic [30:0]         min_linear,
	input  logic [15:0]         heading_gain,
	input  logic [15:0]         attraction_gain,
	input  logic [30:0]         spin_rate,
	input  logic [14:0]         heading_threshold,
	output logic [30:0]         linear_cmd,
	output logic signed [31:0]  angular_cmd,
	output logic                reached,
	output logic [1:0]          mode
);
	import gtg_pkg::*;

	mode_t               mode_q;
	logic signed [31:0]  goal_x_q, goal_y_q, px_q, py_q;
	logic signed [15:0]  yaw_q;
	logic                op_q, zero_q;
	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [STEP_W-1:0]   i_q;
	logic [CW-2:0]       mag;
	logic [48:0]         pa_q, pb_q;
	logic [34:0]         dist_q;
	logic [50:0]         lin_q;
	logic signed [17:0]  err_q;
	logic signed [33:0]  ang_q;
	logic [30:0]         lin_o_q;
	logic signed [31:0]  ang_o_q;
	logic                rch_q;

	logic signed [32:0]  dx, dy;
	logic signed [CW-1:0] sx, sy;
	logic [4:0]          ii;
	logic [50:0]         lin_c;
	logic signed [17:0]  tgt, e0;
	logic signed [ZW:0]  zr;

	assign dx = 33'(goal_x_q) - 33'(px_q);
	assign dy = 33'(goal_y_q) - 33'(py_q);
	assign ii = (CORDIC_STEPS > 32) ? 5'(i_q) : 5'(i_q);
	assign sx = x_q >>> i_q;
	assign sy = y_q >>> i_q;
	assign mag = x_q[CW-1] ? '0 : x_q[CW-2:0];
	assign sts.is_goal = op_q;
	assign sts.active = (mode_q == MODE_MOVE) || (mode_q == MODE_ROT);
	assign sts.iter_done = (32'(i_q) >= ((CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS) - 1);

	assign zr = 33'(z_q) + 33'sd32768;
	always_comb begin
		tgt = (attraction_gain == '0 || zero_q) ? 18'sd0 : 18'(zr >>> 16);
		e0 = tgt - 18'(yaw_q);
		if (e0 >= PI_Q13) e0 = e0 - TWO_PI_Q13;
		if (e0 >= PI_Q13) e0 = e0 - TWO_PI_Q13;
		if (e0 < -PI_Q13) e0 = e0 + TWO_PI_Q13;
		if (e0 < -PI_Q13) e0 = e0 + TWO_PI_Q13;
		lin_c = lin_q;
		if (lin_c > 51'(max_linear)) lin_c = 51'(max_linear);
		if (lin_c < 51'(min_linear)) lin_c = 51'(min_linear);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STOP;
			goal_x_q <= '0;
			goal_y_q <= '0;
		end else if (cmd.goal && op_q) begin
			goal_x_q <= px_q;
			goal_y_q <= py_q;
			mode_q <= (heading_threshold == '0) ? MODE_MOVE : MODE_ROT;
		end else if (cmd.fin && sts.active) begin
			if (35'(dist_q) < 35'(reach_radius)) mode_q <= MODE_STOP;
			else if (mode_q == MODE_ROT && ((err_q < 0) ? -err_q : err_q) < 18'(heading_threshold))
				mode_q <= MODE_MOVE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			px_q <= pos_x;
			py_q <= pos_y;
			yaw_q <= yaw;
		end
		if (cmd.pre) begin
			zero_q <= (dx == 0) && (dy == 0);
			i_q <= '0;
			if (dx < 0) begin
				if (dy >= 0) begin
					x_q <= CW'(dy); y_q <= -CW'(dx); z_q <= HALF_PI_Q29;
				end else begin
					x_q <= -CW'(dy); y_q <= CW'(dx); z_q <= -HALF_PI_Q29;
				end
			end else begin
				x_q <= CW'(dx); y_q <= CW'(dy); z_q <= '0;
			end
		end
		if (cmd.iter) begin
			i_q <= i_q + 1'b1;
			if (y_q >= 0) begin
				x_q <= x_q + sy; y_q <= y_q - sx; z_q <= z_q + atan_q29(ii);
			end else begin
				x_q <= x_q - sy; y_q <= y_q + sx; z_q <= z_q - atan_q29(ii);
			end
		end
		if (cmd.mul1) pa_q <= 49'(mag >> 16) * 49'(INV_GAIN_Q30);
		if (cmd.mul2) pb_q <= 49'(mag[15:0]) * 49'(INV_GAIN_Q30);
		if (cmd.sum) dist_q <= 35'((pa_q >> 14) + ((({35'd0, pa_q[13:0]} << 16) + 49'(pb_q)) >> 30));
		if (cmd.lin) begin
			lin_q <= 51'(attraction_gain) * 51'(dist_q) >> 8;
			err_q <= e0;
		end
		if (cmd.err) ang_q <= (34'(signed'({1'b0, heading_gain})) * 34'(err_q)) >>> 5;
		if (cmd.fin) begin
			lin_o_q <= '0;
			ang_o_q <= '0;
			rch_q <= 1'b0;
			if (sts.active) begin
				if (35'(dist_q) < 35'(reach_radius)) rch_q <= 1'b1;
				else if (mode_q == MODE_ROT) begin
					if (((err_q < 0) ? -err_q : err_q) < 18'(heading_threshold)) ang_o_q <= '0;
					else ang_o_q <= (ang_q < 0) ? -32'(spin_rate) : 32'(spin_rate);
				end else begin
					lin_o_q <= 31'(lin_c);
					ang_o_q <= 32'(ang_q);
				end
			end
		end
	end

	assign linear_cmd = lin_o_q;
	assign angular_cmd = ang_o_q;
	assign reached = rch_q;
	assign mode = (mode_q == MODE_RSV) ? MODE_STOP : mode_q;
endmodule

/* design/go_to_goal_motion_controller.sv */
// Top level: go-to-goal motion controller with rotate-in-place.
// Goal transfer: no result. A tick result passes the goal, prepare, CORDIC iteration, multiply-high,
// multiply-low, sum, linear, error and final states, the CORDIC unit doing one rotation per cycle.
// One item at a time: a new tick is not taken until the result of the last has been accepted.
// A tick while stopped skips from the goal state straight to the final state.
// arst_n clears the mode to stopped, the goal to zero and the configuration registers to defaults.
module go_to_goal_motion_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                operation,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [15:0]  yaw,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [30:0]         linear_cmd,
	output logic signed [31:0]  angular_cmd,
	output logic                reached,
	output logic [1:0]          mode,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import gtg_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [30:0] tol_q, maxl_q, minl_q, spin_q;
	logic [15:0] hg_q, ag_q;
	logic [14:0] thr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 31'd6554; maxl_q <= 31'd13107; minl_q <= 31'd3277;
			hg_q <= 16'd128; ag_q <= 16'd128; spin_q <= 31'd196608; thr_q <= 15'd3277;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TOL:   tol_q <= cfg_data[30:0];
				CFG_MAXL:  maxl_q <= cfg_data[30:0];
				CFG_MINL:  minl_q <= cfg_data[30:0];
				CFG_HGAIN: hg_q <= cfg_data[15:0];
				CFG_AGAIN: ag_q <= cfg_data[15:0];
				CFG_SPIN:  spin_q <= cfg_data[30:0];
				CFG_THR:   thr_q <= cfg_data[14:0];
				default:   ;
			endcase
		end
	end

	gtg_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
	);

	gtg_dp u_dp (
		.clk, .arst_n, .cmd, .sts, .operation, .pos_x, .pos_y, .yaw,
		.reach_radius(tol_q), .max_linear(maxl_q), .min_linear(minl_q),
		.heading_gain(hg_q), .attraction_gain(ag_q), .spin_rate(spin_q),
		.heading_threshold(thr_q),
		.linear_cmd, .angular_cmd, .reached, .mode
	);
endmodule

/* design/gtg_checker.sv */
// Checker: port-level properties of the go-to-goal controller, bound to the top level.
module gtg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [30:0] linear_cmd,
	input logic signed [31:0] angular_cmd,
	input logic        reached,
	input logic [1:0]  mode
);
	import gtg_pkg::*;

	a_reach_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reached |-> mode == MODE_STOP && linear_cmd == '0 && angular_cmd == '0)
		else $error("reached result not a stop");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");
	a_stopped_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode == MODE_STOP |-> linear_cmd == '0 && angular_cmd == '0)
		else $error("motion while stopped");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(linear_cmd) && $stable(angular_cmd))
		else $error("stalled result changed");
endmodule

bind go_to_goal_motion_controller gtg_checker u_chk (
	.clk, .arst_n, .in_stall, .out_valid, .out_stall,
	.linear_cmd, .angular_cmd, .reached, .mode
);
